@@ hw/rtl/qsl_pkg.sv @@
// Shared constants for the quicksort Lomuto sorter: defaults, item kinds and status codes.
package qsl_pkg;

   localparam int QSL_DEPTH      = 256;
   localparam int QSL_DATA_WIDTH = 32;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_READ = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

endpackage

@@ hw/rtl/quicksort_lomuto_sorter_unit.sv @@
// Quicksort sorter with Lomuto partitioning over an element memory with one write and one read port.
//
// Requests arrive on the req_ channel as transactions of two kinds. A load stores
// req_value at the next free position; a load with req_last set also starts an
// in-place ascending sort of the loaded set. A read returns the element at req_index.
// Every request produces exactly one response transaction on the rsp_ channel, in the
// cycle after acceptance, carrying the data, the current element count and a status.
// Loads and reads are taken at one per cycle while the response register is free or
// being drained. While a sort runs req_ready is low. The sort is sequenced over the
// element memory, which has one write port and one registered read port: a partition
// reads the pivot, compares each element of the range against it, writes both elements
// of each swap, moves the pivot into place and then picks the next range; a range taken
// from the stack passes through a pop step first. The response of the final load is
// presented while the sort runs. When rsp_ready is low the response holds and no new
// request is taken. Reset empties the set and returns to the loading phase; the memory
// is not cleared.
module quicksort_lomuto_sorter_unit
   import qsl_pkg::*;
#(
   parameter int DEPTH      = QSL_DEPTH,
   parameter int DATA_WIDTH = QSL_DATA_WIDTH,
   localparam int IDX_W     = $clog2(DEPTH),
   localparam int CNT_W     = $clog2(DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_kind,
   input  logic [DATA_WIDTH-1:0] req_value,
   input  logic [IDX_W-1:0]      req_index,
   input  logic                  req_last,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DATA_WIDTH-1:0] rsp_data,
   output logic [CNT_W-1:0]      rsp_count,
   output logic [1:0]            rsp_status
);

   localparam int STK_D  = IDX_W + 1;
   localparam int STK_IW = $clog2(STK_D);
   localparam int SP_W   = $clog2(STK_D + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_PART  = 4'd1;
   localparam logic [3:0] S_PIVOT = 4'd2;
   localparam logic [3:0] S_CMP   = 4'd3;
   localparam logic [3:0] S_SWAP1 = 4'd4;
   localparam logic [3:0] S_SWAP2 = 4'd5;
   localparam logic [3:0] S_FIN   = 4'd6;
   localparam logic [3:0] S_FIN2  = 4'd7;
   localparam logic [3:0] S_NEXT  = 4'd8;
   localparam logic [3:0] S_POP   = 4'd9;

   logic [DATA_WIDTH-1:0] mem_array [DEPTH];
   logic [DATA_WIDTH-1:0] rdata_ff;
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_waddr;
   logic [DATA_WIDTH-1:0] mem_wdata;
   logic                  mem_re;
   logic [IDX_W-1:0]      mem_raddr;

   logic [IDX_W-1:0] stk_lo_ff [STK_D];
   logic [IDX_W-1:0] stk_hi_ff [STK_D];
   logic             push;
   logic [IDX_W-1:0] push_lo;
   logic [IDX_W-1:0] push_hi;
   logic [SP_W-1:0]  sp_dec;

   logic [3:0]            state_ff, state_in;
   logic [SP_W-1:0]       sp_ff, sp_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  sorted_ff, sorted_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic                  rsp_mem_ff, rsp_mem_in;
   logic [IDX_W-1:0]      lo_ff, lo_in;
   logic [IDX_W-1:0]      hi_ff, hi_in;
   logic [IDX_W-1:0]      s_ff, s_in;
   logic [IDX_W-1:0]      i_ff, i_in;
   logic [DATA_WIDTH-1:0] pivot_ff, pivot_in;
   logic [DATA_WIDTH-1:0] x_ff, x_in;
   logic [DATA_WIDTH-1:0] y_ff, y_in;

   logic                  req_accept;
   logic                  elem_less;
   logic [CNT_W-1:0]      cnt_eff;
   logic [CNT_W-1:0]      cnt_new;
   logic [IDX_W-1:0]      left_n;
   logic [IDX_W-1:0]      right_n;

   assign req_ready  = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_accept = req_valid && req_ready;
   assign elem_less  = $signed(rdata_ff) < $signed(pivot_ff);
   assign sp_dec     = sp_ff - 1'b1;
   assign left_n     = s_ff - lo_ff;
   assign right_n    = hi_ff - s_ff;
   assign cnt_eff    = sorted_ff ? '0 : count_ff;
   assign cnt_new    = (cnt_eff < CNT_W'(DEPTH)) ? cnt_eff + 1'b1 : cnt_eff;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_mem_ff ? rdata_ff : '0;
   assign rsp_count  = rsp_count_ff;
   assign rsp_status = rsp_status_ff;

   always_comb begin
      state_in      = state_ff;
      sp_in         = sp_ff;
      count_in      = count_ff;
      sorted_in     = sorted_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      rsp_mem_in    = rsp_mem_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      s_in          = s_ff;
      i_in          = i_ff;
      pivot_in      = pivot_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      mem_we        = 1'b0;
      mem_waddr     = s_ff;
      mem_wdata     = x_ff;
      mem_re        = 1'b0;
      mem_raddr     = i_ff;
      push          = 1'b0;
      push_lo       = lo_ff;
      push_hi       = hi_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               rsp_valid_in = 1'b1;
               if (req_kind == KIND_LOAD) begin
                  sorted_in    = 1'b0;
                  rsp_mem_in   = 1'b0;
                  count_in     = cnt_new;
                  rsp_count_in = cnt_new;
                  if (cnt_eff < CNT_W'(DEPTH)) begin
                     mem_we        = 1'b1;
                     mem_waddr     = IDX_W'(cnt_eff);
                     mem_wdata     = req_value;
                     rsp_status_in = STATUS_OK;
                  end else begin
                     rsp_status_in = STATUS_FULL;
                  end
                  if (req_last) begin
                     sp_in    = '0;
                     lo_in    = '0;
                     hi_in    = IDX_W'(cnt_new - 1'b1);
                     state_in = (cnt_new > CNT_W'(1)) ? S_PART : S_POP;
                  end
               end else begin
                  rsp_count_in = count_ff;
                  if (CNT_W'(req_index) < count_ff) begin
                     mem_re        = 1'b1;
                     mem_raddr     = req_index;
                     rsp_mem_in    = 1'b1;
                     rsp_status_in = STATUS_OK;
                  end else begin
                     rsp_mem_in    = 1'b0;
                     rsp_status_in = STATUS_RANGE;
                  end
               end
            end
         end
         S_PART: begin
            mem_re    = 1'b1;
            mem_raddr = lo_ff;
            state_in  = S_PIVOT;
         end
         S_PIVOT: begin
            pivot_in  = rdata_ff;
            s_in      = lo_ff;
            i_in      = lo_ff + 1'b1;
            mem_re    = 1'b1;
            mem_raddr = lo_ff + 1'b1;
            state_in  = S_CMP;
         end
         S_CMP: begin
            if (elem_less) begin
               x_in      = rdata_ff;
               s_in      = s_ff + 1'b1;
               mem_re    = 1'b1;
               mem_raddr = s_ff + 1'b1;
               state_in  = S_SWAP1;
            end else if (i_ff == hi_ff) begin
               mem_re    = 1'b1;
               mem_raddr = s_ff;
               state_in  = S_FIN;
            end else begin
               i_in      = i_ff + 1'b1;
               mem_re    = 1'b1;
               mem_raddr = i_ff + 1'b1;
            end
         end
         S_SWAP1: begin
            mem_we    = 1'b1;
            mem_waddr = s_ff;
            mem_wdata = x_ff;
            y_in      = rdata_ff;
            state_in  = S_SWAP2;
         end
         S_SWAP2: begin
            mem_we    = 1'b1;
            mem_waddr = i_ff;
            mem_wdata = y_ff;
            mem_re    = 1'b1;
            if (i_ff == hi_ff) begin
               mem_raddr = s_ff;
               state_in  = S_FIN;
            end else begin
               i_in      = i_ff + 1'b1;
               mem_raddr = i_ff + 1'b1;
               state_in  = S_CMP;
            end
         end
         S_FIN: begin
            mem_we    = 1'b1;
            mem_waddr = lo_ff;
            mem_wdata = rdata_ff;
            state_in  = S_FIN2;
         end
         S_FIN2: begin
            mem_we    = 1'b1;
            mem_waddr = s_ff;
            mem_wdata = pivot_ff;
            state_in  = S_NEXT;
         end
         S_NEXT: begin
            // The larger side waits on the stack; ranges of fewer than two elements are done.
            if (left_n > right_n) begin
               if (left_n > IDX_W'(1)) begin
                  push    = 1'b1;
                  push_lo = lo_ff;
                  push_hi = s_ff - 1'b1;
                  sp_in   = sp_ff + 1'b1;
               end
               if (right_n > IDX_W'(1)) begin
                  lo_in    = s_ff + 1'b1;
                  state_in = S_PART;
               end else begin
                  state_in = S_POP;
               end
            end else begin
               if (right_n > IDX_W'(1)) begin
                  push    = 1'b1;
                  push_lo = s_ff + 1'b1;
                  push_hi = hi_ff;
                  sp_in   = sp_ff + 1'b1;
               end
               if (left_n > IDX_W'(1)) begin
                  hi_in    = s_ff - 1'b1;
                  state_in = S_PART;
               end else begin
                  state_in = S_POP;
               end
            end
         end
         S_POP: begin
            if (sp_ff == '0) begin
               sorted_in = 1'b1;
               state_in  = S_IDLE;
            end else begin
               lo_in    = stk_lo_ff[sp_dec[STK_IW-1:0]];
               hi_in    = stk_hi_ff[sp_dec[STK_IW-1:0]];
               sp_in    = sp_dec;
               state_in = S_PART;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_array[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem_array[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         stk_lo_ff[sp_ff[STK_IW-1:0]] <= push_lo;
         stk_hi_ff[sp_ff[STK_IW-1:0]] <= push_hi;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         count_ff     <= '0;
         sorted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         count_ff     <= count_in;
         sorted_ff    <= sorted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_mem_ff    <= rsp_mem_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      s_ff          <= s_in;
      i_ff          <= i_in;
      pivot_ff      <= pivot_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
   end

   // A response that is not OK never carries element data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> rsp_data == '0)
      else $error("failed response carries nonzero data");

   // The range stack never grows beyond its allocated depth.
   assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(STK_D))
      else $error("range stack overflow");

   // During the scan the store boundary stays strictly behind the scan index.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CMP |-> s_ff < i_ff)
      else $error("partition boundary passed scan index");

   // The element count never exceeds the store depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("element count beyond store depth");

endmodule
